// ----- src/lin_pkg.sv -----
// shared constants and types for the line intersection pipeline
// no dependencies
package lin_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    // quotient bits produced by the divider, one more than the result width
    localparam int QUOT_BITS = 33;
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // per-coordinate sideband that rides along the divider stages
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic        direct;
        logic        tag;
        logic [31:0] dval;
    } lin_side_t;

endpackage

// ----- src/line_intersection_int.sv -----
// Intersection of two lines given by start and end points, solved by Cramer's rule.
// One line pair is taken per clock while the output is not stalled; each result passes
// through 6 front stages for differences, determinant and numerators, then a divider with one
// quotient bit per stage plus 3 stages for sign handling and saturation. The whole
// pipeline advances together and holds while a result waits to be taken.
// Parallel lines give (sum of the start points + 1) / 2, truncated toward zero, and a cleared flag.
// depends on lin_pkg, lin_front, lin_div
module line_intersection_int #(
    parameter int COORD_WIDTH = lin_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_b_end_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_cross_x,
    output logic signed [31:0]            m_cross_y,
    output logic                          m_lines_cross
);
    import lin_pkg::*;

    localparam int NW = 3 * COORD_WIDTH + 5;
    localparam int TW = 2 * COORD_WIDTH + 3;

    logic                 en;
    logic                 f_valid;
    logic signed [NW-1:0] f_num_x, f_num_y;
    logic signed [TW-1:0] f_det;
    logic                 f_cross, f_dir_x, f_dir_y;
    logic [31:0]          f_dval_x, f_dval_y;
    logic                 vx, vy, tag_x, tag_y;
    logic [31:0]          cx, cy;

    // pipeline moves when the output stage is empty or being drained
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    lin_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .a_sx       (s_a_start_x),
        .a_sy       (s_a_start_y),
        .a_ex       (s_a_end_x),
        .a_ey       (s_a_end_y),
        .b_sx       (s_b_start_x),
        .b_sy       (s_b_start_y),
        .b_ex       (s_b_end_x),
        .b_ey       (s_b_end_y),
        .out_valid  (f_valid),
        .out_num_x  (f_num_x),
        .out_num_y  (f_num_y),
        .out_det    (f_det),
        .out_cross  (f_cross),
        .out_dir_x  (f_dir_x),
        .out_dir_y  (f_dir_y),
        .out_dval_x (f_dval_x),
        .out_dval_y (f_dval_y)
    );

    lin_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_num    (f_num_x),
        .in_det    (f_det),
        .in_direct (f_dir_x),
        .in_dval   (f_dval_x),
        .in_tag    (f_cross),
        .out_valid (vx),
        .out_coord (cx),
        .out_tag   (tag_x)
    );

    lin_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_num    (f_num_y),
        .in_det    (f_det),
        .in_direct (f_dir_y),
        .in_dval   (f_dval_y),
        .in_tag    (f_cross),
        .out_valid (vy),
        .out_coord (cy),
        .out_tag   (tag_y)
    );

    assign m_valid       = vx;
    assign m_cross_x     = $signed(cx);
    assign m_cross_y     = $signed(cy);
    assign m_lines_cross = tag_x;

    // both coordinate lanes must stay in lockstep
    a_lane_valid: assert property (@(posedge aclk) disable iff (!aresetn) vx == vy)
        else $error("coordinate lanes out of step");

    a_lane_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        vx |-> (tag_x == tag_y))
        else $error("parallel flag differs between lanes");

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_cross_x) && $stable(m_cross_y)
                                   && $stable(m_lines_cross)))
        else $error("result changed during stall");

endmodule

// ----- src/lin_front.sv -----
// front pipeline: differences, determinant, split products and numerators
// depends on lin_pkg
module lin_front #(
    parameter int COORD_WIDTH = lin_pkg::COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [COORD_WIDTH-1:0]   a_sx,
    input  logic signed [COORD_WIDTH-1:0]   a_sy,
    input  logic signed [COORD_WIDTH-1:0]   a_ex,
    input  logic signed [COORD_WIDTH-1:0]   a_ey,
    input  logic signed [COORD_WIDTH-1:0]   b_sx,
    input  logic signed [COORD_WIDTH-1:0]   b_sy,
    input  logic signed [COORD_WIDTH-1:0]   b_ex,
    input  logic signed [COORD_WIDTH-1:0]   b_ey,
    output logic                            out_valid,
    output logic signed [3*COORD_WIDTH+4:0] out_num_x,
    output logic signed [3*COORD_WIDTH+4:0] out_num_y,
    output logic signed [2*COORD_WIDTH+2:0] out_det,
    output logic                            out_cross,
    output logic                            out_dir_x,
    output logic                            out_dir_y,
    output logic [31:0]                     out_dval_x,
    output logic [31:0]                     out_dval_y
);
    import lin_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int TW  = 2 * W + 3;
    localparam int LW  = W + 2;
    localparam int HW  = TW - LW;
    localparam int HPW = DW + HW;
    localparam int LPW = DW + LW + 1;
    localparam int NW  = 3 * W + 5;

    function automatic logic signed [HPW-1:0] mul_hi(logic signed [DW-1:0] a,
                                                     logic signed [TW-1:0] w);
        mul_hi = a * $signed(w[TW-1:LW]);
    endfunction

    function automatic logic signed [LPW-1:0] mul_lo(logic signed [DW-1:0] a,
                                                     logic signed [TW-1:0] w);
        mul_lo = a * $signed({1'b0, w[LW-1:0]});
    endfunction

    function automatic logic signed [NW-1:0] join_pp(logic signed [HPW-1:0] h,
                                                     logic signed [LPW-1:0] l);
        join_pp = (NW'(h) <<< LW) + NW'(l);
    endfunction

    // (s + 1) / 2 truncated toward zero
    function automatic logic [31:0] half_up(logic signed [DW-1:0] s);
        logic signed [DW:0] v;
        v = (DW+1)'(s) + (DW+1)'(1);
        if (v < 0) begin
            v = v + (DW+1)'(1);
        end
        half_up = 32'(v >>> 1);
    endfunction

    logic [5:0] v_reg;

    // stage 1
    logic signed [DW-1:0] r1_1_reg, r2_1_reg, m11_1_reg, m12_1_reg, m21_1_reg, m22_1_reg;
    logic signed [DW-1:0] sx_1_reg, sy_1_reg;
    logic signed [W-1:0]  asx_1_reg, bsx_1_reg, asy_1_reg, bsy_1_reg;
    logic                 eqax_1_reg, eqbx_1_reg, eqay_1_reg, eqby_1_reg;
    // stage 2
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [DW-1:0] m11_2_reg, m12_2_reg, m21_2_reg, m22_2_reg, sx_2_reg, sy_2_reg;
    logic signed [W-1:0]  asx_2_reg, bsx_2_reg, asy_2_reg, bsy_2_reg;
    logic                 eqax_2_reg, eqbx_2_reg, eqay_2_reg, eqby_2_reg;
    // stage 3
    logic signed [TW-1:0] det_3_reg, t1_reg, t2_reg;
    logic signed [DW-1:0] m11_3_reg, m12_3_reg, m21_3_reg, m22_3_reg, sx_3_reg, sy_3_reg;
    logic signed [W-1:0]  asx_3_reg, bsx_3_reg, asy_3_reg, bsy_3_reg;
    logic                 eqax_3_reg, eqbx_3_reg, eqay_3_reg, eqby_3_reg;
    // stage 4
    logic signed [HPW-1:0] hx0_reg, hx1_reg, hx2_reg, hy0_reg, hy1_reg, hy2_reg;
    logic signed [LPW-1:0] lx0_reg, lx1_reg, lx2_reg, ly0_reg, ly1_reg, ly2_reg;
    logic signed [TW-1:0]  det_4_reg;
    logic                  cross_4_reg, dirx_4_reg, diry_4_reg;
    logic [31:0]           dvalx_4_reg, dvaly_4_reg;
    logic                  cross_next;
    // stage 5
    logic signed [NW-1:0]  px0_reg, px1_reg, px2_reg, py0_reg, py1_reg, py2_reg;
    logic signed [TW-1:0]  det_5_reg;
    logic                  cross_5_reg, dirx_5_reg, diry_5_reg;
    logic [31:0]           dvalx_5_reg, dvaly_5_reg;
    // stage 6
    logic signed [NW-1:0]  numx_reg, numy_reg;
    logic signed [TW-1:0]  det_6_reg;
    logic                  cross_6_reg, dirx_6_reg, diry_6_reg;
    logic [31:0]           dvalx_6_reg, dvaly_6_reg;

    assign cross_next = (det_3_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_1_reg   <= DW'(a_sx) - DW'(b_sx);
            r2_1_reg   <= DW'(a_sy) - DW'(b_sy);
            m11_1_reg  <= DW'(a_sx) - DW'(a_ex);
            m12_1_reg  <= DW'(b_ex) - DW'(b_sx);
            m21_1_reg  <= DW'(a_sy) - DW'(a_ey);
            m22_1_reg  <= DW'(b_ey) - DW'(b_sy);
            sx_1_reg   <= DW'(a_sx) + DW'(b_sx);
            sy_1_reg   <= DW'(a_sy) + DW'(b_sy);
            asx_1_reg  <= a_sx;
            bsx_1_reg  <= b_sx;
            asy_1_reg  <= a_sy;
            bsy_1_reg  <= b_sy;
            eqax_1_reg <= (a_sx == a_ex);
            eqbx_1_reg <= (b_sx == b_ex);
            eqay_1_reg <= (a_sy == a_ey);
            eqby_1_reg <= (b_sy == b_ey);

            pa_reg     <= m11_1_reg * m22_1_reg;
            pb_reg     <= m12_1_reg * m21_1_reg;
            pc_reg     <= m22_1_reg * r1_1_reg;
            pd_reg     <= m12_1_reg * r2_1_reg;
            pe_reg     <= m11_1_reg * r2_1_reg;
            pf_reg     <= m21_1_reg * r1_1_reg;
            m11_2_reg  <= m11_1_reg;
            m12_2_reg  <= m12_1_reg;
            m21_2_reg  <= m21_1_reg;
            m22_2_reg  <= m22_1_reg;
            sx_2_reg   <= sx_1_reg;
            sy_2_reg   <= sy_1_reg;
            asx_2_reg  <= asx_1_reg;
            bsx_2_reg  <= bsx_1_reg;
            asy_2_reg  <= asy_1_reg;
            bsy_2_reg  <= bsy_1_reg;
            eqax_2_reg <= eqax_1_reg;
            eqbx_2_reg <= eqbx_1_reg;
            eqay_2_reg <= eqay_1_reg;
            eqby_2_reg <= eqby_1_reg;

            det_3_reg  <= TW'(pa_reg) - TW'(pb_reg);
            t1_reg     <= TW'(pc_reg) - TW'(pd_reg);
            t2_reg     <= TW'(pe_reg) - TW'(pf_reg);
            m11_3_reg  <= m11_2_reg;
            m12_3_reg  <= m12_2_reg;
            m21_3_reg  <= m21_2_reg;
            m22_3_reg  <= m22_2_reg;
            sx_3_reg   <= sx_2_reg;
            sy_3_reg   <= sy_2_reg;
            asx_3_reg  <= asx_2_reg;
            bsx_3_reg  <= bsx_2_reg;
            asy_3_reg  <= asy_2_reg;
            bsy_3_reg  <= bsy_2_reg;
            eqax_3_reg <= eqax_2_reg;
            eqbx_3_reg <= eqbx_2_reg;
            eqay_3_reg <= eqay_2_reg;
            eqby_3_reg <= eqby_2_reg;

            // wide operands split in two halves to keep each multiplier narrow
            hx0_reg     <= mul_hi(sx_3_reg, det_3_reg);
            lx0_reg     <= mul_lo(sx_3_reg, det_3_reg);
            hx1_reg     <= mul_hi(m11_3_reg, t1_reg);
            lx1_reg     <= mul_lo(m11_3_reg, t1_reg);
            hx2_reg     <= mul_hi(m12_3_reg, t2_reg);
            lx2_reg     <= mul_lo(m12_3_reg, t2_reg);
            hy0_reg     <= mul_hi(sy_3_reg, det_3_reg);
            ly0_reg     <= mul_lo(sy_3_reg, det_3_reg);
            hy1_reg     <= mul_hi(m21_3_reg, t1_reg);
            ly1_reg     <= mul_lo(m21_3_reg, t1_reg);
            hy2_reg     <= mul_hi(m22_3_reg, t2_reg);
            ly2_reg     <= mul_lo(m22_3_reg, t2_reg);
            det_4_reg   <= det_3_reg;
            cross_4_reg <= cross_next;
            dirx_4_reg  <= !cross_next || eqax_3_reg || eqbx_3_reg;
            diry_4_reg  <= !cross_next || eqay_3_reg || eqby_3_reg;
            dvalx_4_reg <= !cross_next ? half_up(sx_3_reg) :
                           eqax_3_reg ? 32'(asx_3_reg) : 32'(bsx_3_reg);
            dvaly_4_reg <= !cross_next ? half_up(sy_3_reg) :
                           eqay_3_reg ? 32'(asy_3_reg) : 32'(bsy_3_reg);

            px0_reg     <= join_pp(hx0_reg, lx0_reg);
            px1_reg     <= join_pp(hx1_reg, lx1_reg);
            px2_reg     <= join_pp(hx2_reg, lx2_reg);
            py0_reg     <= join_pp(hy0_reg, ly0_reg);
            py1_reg     <= join_pp(hy1_reg, ly1_reg);
            py2_reg     <= join_pp(hy2_reg, ly2_reg);
            det_5_reg   <= det_4_reg;
            cross_5_reg <= cross_4_reg;
            dirx_5_reg  <= dirx_4_reg;
            diry_5_reg  <= diry_4_reg;
            dvalx_5_reg <= dvalx_4_reg;
            dvaly_5_reg <= dvaly_4_reg;

            // det added once as the rounding bias
            numx_reg    <= px0_reg - px1_reg + px2_reg + NW'(det_5_reg);
            numy_reg    <= py0_reg - py1_reg + py2_reg + NW'(det_5_reg);
            det_6_reg   <= det_5_reg;
            cross_6_reg <= cross_5_reg;
            dirx_6_reg  <= dirx_5_reg;
            diry_6_reg  <= diry_5_reg;
            dvalx_6_reg <= dvalx_5_reg;
            dvaly_6_reg <= dvaly_5_reg;
        end
    end

    assign out_valid  = v_reg[5];
    assign out_num_x  = numx_reg;
    assign out_num_y  = numy_reg;
    assign out_det    = det_6_reg;
    assign out_cross  = cross_6_reg;
    assign out_dir_x  = dirx_6_reg;
    assign out_dir_y  = diry_6_reg;
    assign out_dval_x = dvalx_6_reg;
    assign out_dval_y = dvaly_6_reg;

endmodule

// ----- src/lin_div.sv -----
// pipelined restoring divider: numerator / (2*det), truncated, saturated to 32 bits; direct values pass through
// depends on lin_pkg
module lin_div #(
    parameter int COORD_WIDTH = lin_pkg::COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [3*COORD_WIDTH+4:0] in_num,
    input  logic signed [2*COORD_WIDTH+2:0] in_det,
    input  logic                            in_direct,
    input  logic [31:0]                     in_dval,
    input  logic                            in_tag,
    output logic                            out_valid,
    output logic [31:0]                     out_coord,
    output logic                            out_tag
);
    import lin_pkg::*;

    localparam int NW  = 3 * COORD_WIDTH + 5;
    localparam int TW  = 2 * COORD_WIDTH + 3;
    localparam int DVW = TW + 1;
    localparam int QB  = QUOT_BITS;
    localparam int XW  = NW + QB;

    // stage a: magnitudes
    logic             va_reg;
    logic [NW-1:0]    na_reg;
    logic [DVW-1:0]   dma_reg;
    lin_side_t        sa_reg;
    logic [NW-1:0]    nmag_next;
    logic [TW-1:0]    dabs_next;

    // stage b and the quotient stages
    logic [QB:0]      vld_reg;
    logic [DVW-1:0]   rem_reg  [0:QB-1];
    logic [QB-1:0]    quo_reg  [0:QB];
    logic [DVW-1:0]   dm_reg   [0:QB-1];
    lin_side_t        side_reg [0:QB];
    logic [XW-1:0]    xm;
    logic [NW-1:0]    hi_part;
    lin_side_t        sb_next;

    // output stage
    logic             vo_reg;
    logic [31:0]      res_reg;
    logic             tag_reg;
    logic [31:0]      res_next;
    logic [QB-1:0]    q_fin;
    lin_side_t        s_fin;

    assign nmag_next = in_num[NW-1] ? $unsigned(-in_num) : $unsigned(in_num);
    assign dabs_next = in_det[TW-1] ? $unsigned(-in_det) : $unsigned(in_det);

    assign xm      = XW'(na_reg);
    assign hi_part = xm[XW-1:QB];

    always_comb begin
        sb_next     = sa_reg;
        // quotient would need more than QUOT_BITS bits
        sb_next.ovf = (hi_part >= NW'(dma_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg  <= 1'b0;
            vld_reg <= '0;
            vo_reg  <= 1'b0;
        end else if (en) begin
            va_reg  <= in_valid;
            vld_reg <= {vld_reg[QB-1:0], va_reg};
            vo_reg  <= vld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            na_reg        <= nmag_next;
            dma_reg       <= {dabs_next, 1'b0};
            sa_reg.neg    <= in_num[NW-1] ^ in_det[TW-1];
            sa_reg.ovf    <= 1'b0;
            sa_reg.direct <= in_direct;
            sa_reg.tag    <= in_tag;
            sa_reg.dval   <= in_dval;

            rem_reg[0]    <= hi_part[DVW-1:0];
            quo_reg[0]    <= xm[QB-1:0];
            dm_reg[0]     <= dma_reg;
            side_reg[0]   <= sb_next;
        end
    end

    // one quotient bit per stage; quo_reg shifts dividend bits out and quotient bits in
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DVW:0] trial;
        logic         ge;
        assign trial = {rem_reg[k], quo_reg[k][QB-1]};
        assign ge    = (trial >= {1'b0, dm_reg[k]});
        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k+1]  <= {quo_reg[k][QB-2:0], ge};
                side_reg[k+1] <= side_reg[k];
            end
        end
        // the last step needs no remainder or divisor behind it
        if (k < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? DVW'(trial - {1'b0, dm_reg[k]}) : trial[DVW-1:0];
                    dm_reg[k+1]  <= dm_reg[k];
                end
            end
        end
    end

    assign q_fin = quo_reg[QB];
    assign s_fin = side_reg[QB];

    always_comb begin
        if (s_fin.direct) begin
            res_next = s_fin.dval;
        end else if (s_fin.neg) begin
            if (s_fin.ovf || q_fin > QB'(SAT_MIN)) begin
                res_next = SAT_MIN;
            end else begin
                res_next = 32'd0 - q_fin[31:0];
            end
        end else begin
            if (s_fin.ovf || q_fin > QB'(SAT_MAX)) begin
                res_next = SAT_MAX;
            end else begin
                res_next = q_fin[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
            tag_reg <= s_fin.tag;
        end
    end

    assign out_valid = vo_reg;
    assign out_coord = res_reg;
    assign out_tag   = tag_reg;

endmodule
